// ===== design/ttcw_pkg.sv =====
`default_nettype none

package ttcw_pkg;

  // Fixed field widths of the streams and the configuration port.
  localparam int CODE_W  = 8;
  localparam int IDX_W   = 13;
  localparam int COLOR_W = 8;
  localparam int ROWS_W  = 7;
  localparam int COLS_W  = 8;
  localparam int CFG_W   = 8;
  localparam int ADDR_W  = 3;
  // Output tdata: index, glyph, three colours, invert, blink, padded to bytes.
  localparam int OUT_FIELDS_W = IDX_W + CODE_W + 3 * COLOR_W + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Character codes with a meaning of their own.
  localparam logic [CODE_W-1:0] CODE_CR     = 8'h0D;
  localparam logic [CODE_W-1:0] CODE_LF     = 8'h0A;
  localparam logic [CODE_W-1:0] VIS_LOW     = 8'h20;
  localparam logic [CODE_W-1:0] VIS_HIGH    = 8'h7F;
  localparam logic [CODE_W-1:0] MARK_GLYPH  = 8'h5F;
  localparam logic [CODE_W-1:0] ERASE_GLYPH = 8'h20;

  // Reset values of the configuration registers.
  localparam logic [COLOR_W-1:0] RST_COLOR = 8'd255;
  localparam logic [ROWS_W-1:0]  RST_ROWS  = 7'd30;
  localparam logic [COLS_W-1:0]  RST_COLS  = 8'd80;

  // Configuration register indexes.
  typedef enum logic [ADDR_W-1:0] {
    CFG_RED    = 3'd0,
    CFG_GREEN  = 3'd1,
    CFG_BLUE   = 3'd2,
    CFG_INVERT = 3'd3,
    CFG_BLINK  = 3'd4,
    CFG_ROWS   = 3'd5,
    CFG_COLS   = 3'd6
  } cfg_reg_t;

  // One pending command; colour is taken from the configuration on output.
  typedef struct packed {
    logic              is_scroll;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] glyph;
    logic              invert;
    logic              blink;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/text_terminal_cursor_writer.sv =====
`default_nettype none

// Channel   Dir  Ports                              Beat contents
// in_       in   in_tvalid/in_tready/in_tdata       character code
// out_      out  out_tvalid/out_tready/out_tdata,   write or scroll command
//                out_tuser/out_tlast
// cfg_      in   cfg_we/cfg_addr/cfg_wdata          register write
//
// A character is taken into an input register and then, once the bank is free,
// decoded into up to three commands that load the command register bank together
// with the new cursor. The bank drains one beat per cycle while out_tready is high;
// a character that is ignored causes no commands and only moves the cursor.
// Reset clears the cursor to the top left cell and restores the register
// defaults. A stalled output holds the bank and, behind it, the input register.

module text_terminal_cursor_writer
  import ttcw_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  wire                     clk,
  input  wire                     rst_n,
  // in_tdata: [7:0] char_code
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire  [CODE_W-1:0]       in_tdata,
  // out_tdata: [12:0] cell_index, [20:13] glyph, [28:21] cell_red,
  // [36:29] cell_green, [44:37] cell_blue, [45] cell_invert, [46] cell_blink
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: [0] is_scroll
  output logic                    out_tuser,
  output logic                    out_tlast,
  input  wire                     cfg_we,
  input  wire  [ADDR_W-1:0]       cfg_addr,
  input  wire  [CFG_W-1:0]        cfg_wdata
);

  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DW   = 9;
  localparam int PW   = RW + DW;
  localparam int XW   = (PW + 1 > IDX_W) ? PW + 1 : IDX_W;
  localparam logic [DW-1:0] MAXR = DW'(MAX_ROWS);
  localparam logic [DW-1:0] MAXC = DW'(MAX_COLS);

  // Configuration registers.
  logic [COLOR_W-1:0] red_r, green_r, blue_r;
  logic               invert_r, blink_r;
  logic [ROWS_W-1:0]  rows_r;
  logic [COLS_W-1:0]  cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r    <= RST_COLOR;
      green_r  <= RST_COLOR;
      blue_r   <= RST_COLOR;
      invert_r <= 1'b0;
      blink_r  <= 1'b0;
      rows_r   <= RST_ROWS;
      cols_r   <= RST_COLS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_RED:    red_r    <= cfg_wdata;
        CFG_GREEN:  green_r  <= cfg_wdata;
        CFG_BLUE:   blue_r   <= cfg_wdata;
        CFG_INVERT: invert_r <= cfg_wdata[0];
        CFG_BLINK:  blink_r  <= cfg_wdata[0];
        CFG_ROWS:   rows_r   <= cfg_wdata[ROWS_W-1:0];
        CFG_COLS:   cols_r   <= cfg_wdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake state.
  logic              in_v_r;
  logic [CODE_W-1:0] code_r;
  logic [1:0]        cnt_r, cnt_nxt;
  cmd_t              bank_r [3];
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              pop, bank_free, advance;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign bank_free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign advance    = in_v_r && bank_free;
  assign in_tready  = !in_v_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      code_r <= in_tdata;
    end
  end

  // Screen size limited to the supported range, as last row and last column.
  logic [DW-1:0] nr, nc;
  logic [RW-1:0] last_row;
  logic [CW-1:0] last_col;

  always_comb begin
    nr = {{(DW-ROWS_W){1'b0}}, rows_r};
    if (nr == '0) nr = DW'(1);
    else if (nr > MAXR) nr = MAXR;
    nc = {{(DW-COLS_W){1'b0}}, cols_r};
    if (nc == '0) nc = DW'(1);
    else if (nc > MAXC) nc = MAXC;
  end

  assign last_row = RW'(nr - DW'(1));
  assign last_col = CW'(nc - DW'(1));

  // Cursor pulled back inside the screen.
  logic [RW-1:0] row_c;
  logic [CW-1:0] col_c;

  assign row_c = (row_r > last_row) ? last_row : row_r;
  assign col_c = (col_r > last_col) ? last_col : col_r;

  // Start of the cursor's row and the cursor's own cell.
  logic [XW-1:0] prod, base;

  assign prod = XW'(row_c) * XW'(nc);
  assign base = prod + XW'(col_c);

  // Decode of the character and the cursor move.
  logic visible, is_cr, is_lf, wrap, move_down, at_bottom, has_scroll, active;
  logic [XW-1:0] mark_idx;
  logic [1:0]    n_cmds;
  cmd_t          first_cmd, scroll_cmd, mark_cmd;

  always_comb begin
    visible    = (code_r >= VIS_LOW) && (code_r <= VIS_HIGH);
    is_cr      = (code_r == CODE_CR);
    is_lf      = (code_r == CODE_LF);
    active     = visible || is_cr || is_lf;
    wrap       = visible && (col_c == last_col);
    move_down  = wrap || is_lf;
    at_bottom  = (row_c == last_row);
    has_scroll = move_down && at_bottom;

    row_nxt = row_c;
    col_nxt = col_c;
    if (move_down && !at_bottom) row_nxt = row_c + RW'(1);
    if (visible && !wrap) col_nxt = col_c + CW'(1);
    else if (wrap || is_cr) col_nxt = '0;

    // New cursor cell, worked out from the old one.
    if (visible && !wrap) mark_idx = base + XW'(1);
    else if (wrap) mark_idx = has_scroll ? prod : prod + XW'(nc);
    else if (is_cr) mark_idx = prod;
    else mark_idx = has_scroll ? base : base + XW'(nc);

    first_cmd.is_scroll = 1'b0;
    first_cmd.idx       = base[IDX_W-1:0];
    first_cmd.glyph     = visible ? code_r : ERASE_GLYPH;
    first_cmd.invert    = visible && invert_r;
    first_cmd.blink     = visible && blink_r;

    scroll_cmd           = '0;
    scroll_cmd.is_scroll = 1'b1;

    mark_cmd.is_scroll = 1'b0;
    mark_cmd.idx       = mark_idx[IDX_W-1:0];
    mark_cmd.glyph     = MARK_GLYPH;
    mark_cmd.invert    = 1'b0;
    mark_cmd.blink     = 1'b1;

    n_cmds = has_scroll ? 2'd3 : 2'd2;
  end

  // Cursor state, updated with the clamped position even for ignored codes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (advance) begin
      row_r <= active ? row_nxt : row_c;
      col_r <= active ? col_nxt : col_c;
    end
  end

  // Command bank: loaded whole, drained from entry 0 by shifting.
  always_comb begin
    cnt_nxt = cnt_r;
    if (advance && active) cnt_nxt = n_cmds;
    else if (pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && active) begin
      bank_r[0] <= first_cmd;
      bank_r[1] <= has_scroll ? scroll_cmd : mark_cmd;
      bank_r[2] <= mark_cmd;
    end else if (pop) begin
      bank_r[0] <= bank_r[1];
      bank_r[1] <= bank_r[2];
    end
  end

  // Output beat; a scroll carries zeros in every data field.
  logic [COLOR_W-1:0] out_red, out_green, out_blue;

  assign out_red   = bank_r[0].is_scroll ? '0 : red_r;
  assign out_green = bank_r[0].is_scroll ? '0 : green_r;
  assign out_blue  = bank_r[0].is_scroll ? '0 : blue_r;

  assign out_tdata = OUT_DATA_W'({bank_r[0].blink, bank_r[0].invert, out_blue, out_green,
                                  out_red, bank_r[0].glyph, bank_r[0].idx});
  assign out_tuser = bank_r[0].is_scroll;
  assign out_tlast = (cnt_r == 2'd1);

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ttcw_pkg::*;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 128;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 8;
  localparam int PER_PHASE   = 17;

  // One video-memory command as it leaves the block.
  typedef struct packed {
    logic              scroll;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] glyph;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              inv;
    logic              blink;
    logic              is_last;
  } vram_cmd_t;

  // One row of the directed table: a register write or a character.
  typedef struct packed {
    logic              is_cfg;
    cfg_reg_t          sel;
    logic [7:0]        val;
    logic              typed;
    logic [1:0]        n_res;
    logic [IDX_W-1:0]  first_idx;
    logic [IDX_W-1:0]  mark_idx;
  } stim_row_t;

  typedef enum {SCN_SMALL, SCN_TALL, SCN_WIDE, SCN_ANY, SCN_EXTREME} screen_plan_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [CODE_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_we;
  logic [ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  // Shadow of the configuration and of the cursor.
  logic [7:0] red_cfg, green_cfg, blue_cfg;
  logic inv_en, blk_en;
  logic [ROWS_W-1:0] rows_cfg;
  logic [COLS_W-1:0] cols_cfg;
  int cur_row, cur_col;

  vram_cmd_t cmds_due[$];
  vram_cmd_t fresh_cmds[$];
  stim_row_t dir_rows[$];

  int fail_count = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int scrolls_checked = 0;
  int screen_settings = 0;
  int burst_left = 0;
  bit hold_out = 1'b0;

  screen_plan_t phase_plan [8] = '{SCN_SMALL, SCN_TALL, SCN_TALL, SCN_WIDE,
                                   SCN_ANY, SCN_EXTREME, SCN_SMALL, SCN_ANY};
  logic [7:0] rows_edge [4] = '{8'd0, 8'd1, 8'd64, 8'd127};
  logic [7:0] cols_edge [4] = '{8'd0, 8'd1, 8'd128, 8'd255};

  text_terminal_cursor_writer #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Builds a command with the current colour; a scroll carries nothing else.
  function automatic vram_cmd_t make_cmd(input bit scroll, input int idx,
                                         input logic [7:0] glyph, input bit inv,
                                         input bit blink, input bit is_last);
    vram_cmd_t c;
    c = '0;
    c.scroll  = scroll;
    c.is_last = is_last;
    if (!scroll) begin
      c.idx   = idx[IDX_W-1:0];
      c.glyph = glyph;
      c.red   = red_cfg;
      c.green = green_cfg;
      c.blue  = blue_cfg;
      c.inv   = inv;
      c.blink = blink;
    end
    return c;
  endfunction

  // Works out the commands one character causes and moves the shadow cursor.
  function automatic void compute_commands(input logic [7:0] code);
    int nr, nc;
    bit move_down;
    fresh_cmds.delete();
    move_down = 1'b0;
    nr = (rows_cfg == 0) ? 1 : ((rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg));
    nc = (cols_cfg == 0) ? 1 : ((cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg));
    // A screen that shrank may have left the cursor outside it.
    if (cur_row >= nr) cur_row = nr - 1;
    if (cur_col >= nc) cur_col = nc - 1;
    if (code >= VIS_LOW && code <= VIS_HIGH) begin
      fresh_cmds.push_back(make_cmd(1'b0, cur_row * nc + cur_col, code, inv_en, blk_en, 1'b0));
      if (cur_col < nc - 1) begin
        cur_col++;
      end else begin
        cur_col   = 0;
        move_down = 1'b1;
      end
    end else if (code == CODE_CR || code == CODE_LF) begin
      fresh_cmds.push_back(make_cmd(1'b0, cur_row * nc + cur_col, ERASE_GLYPH,
                                    1'b0, 1'b0, 1'b0));
      if (code == CODE_CR) cur_col = 0;
      else move_down = 1'b1;
    end else begin
      return;
    end
    // Below the bottom row the screen scrolls instead of the cursor moving.
    if (move_down) begin
      if (cur_row < nr - 1) cur_row++;
      else fresh_cmds.push_back(make_cmd(1'b1, 0, '0, 1'b0, 1'b0, 1'b0));
    end
    fresh_cmds.push_back(make_cmd(1'b0, cur_row * nc + cur_col, MARK_GLYPH, 1'b0, 1'b1, 1'b1));
  endfunction

  function automatic void commit_fresh();
    foreach (fresh_cmds[i]) cmds_due.push_back(fresh_cmds[i]);
  endfunction

  function automatic string cmd_text(input vram_cmd_t c);
    return $sformatf("scroll=%0b idx=%0d glyph=%02h rgb=%02h/%02h/%02h inv=%0b blink=%0b last=%0b",
                     c.scroll, c.idx, c.glyph, c.red, c.green, c.blue, c.inv, c.blink,
                     c.is_last);
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(VIS_LOW, VIS_HIGH));
    if (r < 72) return CODE_CR;
    if (r < 87) return CODE_LF;
    // Noise: any byte that the block ignores.
    do c = 8'($urandom_range(0, 255));
    while ((c >= VIS_LOW && c <= VIS_HIGH) || c == CODE_CR || c == CODE_LF);
    return c;
  endfunction

  function automatic void add_char(input logic [7:0] code, input bit typed, input int n,
                                   input int first_idx, input int mark_idx);
    stim_row_t row;
    row           = '0;
    row.val       = code;
    row.typed     = typed;
    row.n_res     = n[1:0];
    row.first_idx = first_idx[IDX_W-1:0];
    row.mark_idx  = mark_idx[IDX_W-1:0];
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_reg_t sel, input logic [7:0] value);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.sel    = sel;
    row.val    = value;
    dir_rows.push_back(row);
  endfunction

  // Offers one character in bursts with random gaps and waits until it is accepted.
  task automatic send_char(input logic [7:0] code);
    int gap;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_accepted++;
  endtask

  // Stops offering and waits until every command due has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input cfg_reg_t sel, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    case (sel)
      CFG_RED:    red_cfg   = value;
      CFG_GREEN:  green_cfg = value;
      CFG_BLUE:   blue_cfg  = value;
      CFG_INVERT: inv_en    = value[0];
      CFG_BLINK:  blk_en    = value[0];
      CFG_ROWS:   rows_cfg  = value[ROWS_W-1:0];
      CFG_COLS:   cols_cfg  = value;
      default: ;
    endcase
  endtask

  task automatic program_phase(input screen_plan_t plan);
    logic [7:0] rows_v, cols_v, r, g, b;
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case (plan)
      SCN_SMALL: begin
        rows_v = 8'($urandom_range(1, 4));
        cols_v = 8'($urandom_range(1, 6));
      end
      // A single column walks the cursor down fast towards the bottom rows.
      SCN_TALL: begin
        rows_v = 8'(MAX_ROWS);
        cols_v = 8'd1;
      end
      SCN_WIDE: begin
        rows_v = 8'(MAX_ROWS);
        cols_v = 8'(MAX_COLS);
      end
      SCN_ANY: begin
        rows_v = 8'($urandom_range(0, 255));
        cols_v = 8'($urandom_range(0, 255));
      end
      default: begin
        rows_v = rows_edge[$urandom_range(0, 3)];
        cols_v = cols_edge[$urandom_range(0, 3)];
        r      = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        g      = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        b      = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    endcase
    write_reg(CFG_RED, r);
    write_reg(CFG_GREEN, g);
    write_reg(CFG_BLUE, b);
    write_reg(CFG_INVERT, 8'($urandom_range(0, 255)));
    write_reg(CFG_BLINK, 8'($urandom_range(0, 255)));
    write_reg(CFG_ROWS, rows_v);
    write_reg(CFG_COLS, cols_v);
    cfg_we <= 1'b0;
    screen_settings++;
  endtask

  // Output side: stalls in changing patterns, with one long hold-off on request.
  initial begin
    int mode, span;
    mode = 0;
    span = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(4, 40);
        end
        span--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  // Each output beat is compared with the oldest command due.
  always @(posedge clk) begin
    vram_cmd_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[12:0], out_tdata[20:13], out_tdata[28:21],
             out_tdata[36:29], out_tdata[44:37], out_tdata[45], out_tdata[46], out_tlast};
      if (cmds_due.size() == 0) begin
        note_failure($sformatf("Unexpected beat at %0t: %s", $realtime, cmd_text(got)));
      end else begin
        want = cmds_due.pop_front();
        if (got !== want)
          note_failure($sformatf("Mismatch at %0t\n  expected %s\n  actual   %s",
                                 $realtime, cmd_text(want), cmd_text(got)));
        results_checked++;
        if (want.scroll) scrolls_checked++;
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    bit prev_char, vis;
    int counted;
    logic [7:0] code;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;

    red_cfg   = RST_COLOR;
    green_cfg = RST_COLOR;
    blue_cfg  = RST_COLOR;
    inv_en    = 1'b0;
    blk_en    = 1'b0;
    rows_cfg  = RST_ROWS;
    cols_cfg  = RST_COLS;
    cur_row   = 0;
    cur_col   = 0;

    // Directed table; typed rows give count, first index and mark index.
    // Register defaults: 30 rows of 80 columns.
    add_char(8'h41, 1'b1, 2, 0, 1);
    add_char(VIS_LOW, 1'b1, 2, 1, 2);
    add_char(VIS_HIGH, 1'b1, 2, 2, 3);
    add_char(8'h00, 1'b1, 0, 0, 0);
    add_char(8'hFF, 1'b1, 0, 0, 0);
    add_char(8'h1F, 1'b1, 0, 0, 0);
    add_char(8'h80, 1'b1, 0, 0, 0);
    add_char(CODE_CR, 1'b1, 2, 3, 0);
    add_char(CODE_LF, 1'b1, 2, 0, 80);
    // One cell: every printable character and line feed scrolls; the cursor left on row 1 is pulled back.
    add_cfg(CFG_RED, 8'h00);
    add_cfg(CFG_GREEN, 8'hFF);
    add_cfg(CFG_BLUE, 8'h00);
    add_cfg(CFG_INVERT, 8'h01);
    add_cfg(CFG_BLINK, 8'h01);
    add_cfg(CFG_ROWS, 8'd1);
    add_cfg(CFG_COLS, 8'd1);
    add_char(8'h5A, 1'b1, 3, 0, 0);
    add_char(CODE_LF, 1'b1, 3, 0, 0);
    add_char(CODE_CR, 1'b1, 2, 0, 0);
    // Zero rows and columns count as one.
    add_cfg(CFG_RED, 8'hFF);
    add_cfg(CFG_GREEN, 8'h00);
    add_cfg(CFG_BLUE, 8'hFF);
    add_cfg(CFG_ROWS, 8'd0);
    add_cfg(CFG_COLS, 8'd0);
    add_char(8'h7E, 1'b1, 3, 0, 0);
    // Largest screen, then sizes beyond it that are limited.
    add_cfg(CFG_INVERT, 8'h00);
    add_cfg(CFG_BLINK, 8'h00);
    add_cfg(CFG_ROWS, 8'd64);
    add_cfg(CFG_COLS, 8'd128);
    add_char(8'h61, 1'b1, 2, 0, 1);
    add_cfg(CFG_RED, 8'hA5);
    add_cfg(CFG_GREEN, 8'h5A);
    add_cfg(CFG_BLUE, 8'h0F);
    add_cfg(CFG_ROWS, 8'd127);
    add_cfg(CFG_COLS, 8'd255);
    add_char(CODE_LF, 1'b1, 2, 1, 129);
    add_char(8'h71, 1'b0, 0, 0, 0);
    // Shrinking the screen pulls both row and column back inside it.
    add_cfg(CFG_ROWS, 8'd1);
    add_cfg(CFG_COLS, 8'd2);
    add_char(8'h78, 1'b1, 3, 1, 0);
    add_cfg(CFG_INVERT, 8'h01);
    add_cfg(CFG_ROWS, 8'd2);
    add_cfg(CFG_COLS, 8'd3);
    add_char(8'h30, 1'b0, 0, 0, 0);
    add_char(8'h31, 1'b0, 0, 0, 0);
    add_char(8'h32, 1'b0, 0, 0, 0);
    add_char(8'h33, 1'b0, 0, 0, 0);
    add_char(CODE_CR, 1'b0, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    prev_char = 1'b0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        if (prev_char) begin
          wait_drained();
          screen_settings++;
        end
        write_reg(row.sel, row.val);
        prev_char = 1'b0;
      end else begin
        cfg_we <= 1'b0;
        send_char(row.val);
        compute_commands(row.val);
        if (row.typed) begin
          fresh_cmds.delete();
          if (row.n_res != 0) begin
            vis = (row.val >= VIS_LOW && row.val <= VIS_HIGH);
            fresh_cmds.push_back(make_cmd(1'b0, int'(row.first_idx),
                                          vis ? row.val : ERASE_GLYPH,
                                          vis ? inv_en : 1'b0, vis ? blk_en : 1'b0, 1'b0));
            if (row.n_res == 3) fresh_cmds.push_back(make_cmd(1'b1, 0, '0, 1'b0, 1'b0, 1'b0));
            fresh_cmds.push_back(make_cmd(1'b0, int'(row.mark_idx), MARK_GLYPH,
                                          1'b0, 1'b1, 1'b1));
          end
        end
        commit_fresh();
        prev_char = 1'b1;
      end
    end

    // Random part: one screen setting per phase, mostly printable text.
    foreach (phase_plan[p]) begin
      wait_drained();
      program_phase(phase_plan[p]);
      if (p == 2) begin
        hold_out   = 1'b1;
        burst_left = 60;
      end
      counted = 0;
      while (counted < PER_PHASE) begin
        code = pick_code();
        send_char(code);
        compute_commands(code);
        if (fresh_cmds.size() != 0) counted++;
        commit_fresh();
      end
    end

    wait_drained();
    $display("Sent %0d characters over %0d screen settings; %0d commands checked, %0d scrolls.",
             items_accepted, screen_settings, results_checked, scrolls_checked);
    $display("Screens ran from one cell past the largest size, with a long output hold-off.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== text_terminal_cursor_writer.f =====
design/ttcw_pkg.sv
design/text_terminal_cursor_writer.sv
tb/sv/testbench.sv
